FILE: rtl/lfms_pkg.sv
// ----------------------------------------------------------------------------
// lfms_pkg
// Shared codes and types of the leftmost-fill multi-stack core: operation
// codes, result status codes and the selection summary passed between the
// target picker and the top level.
// ----------------------------------------------------------------------------
package lfms_pkg;

	// Operation codes carried on the opcode field.
	localparam logic [1:0] OP_PUSH      = 2'd0;
	localparam logic [1:0] OP_POP_RIGHT = 2'd1;
	localparam logic [1:0] OP_POP_AT    = 2'd2;

	// Result status codes.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// Width of the fixed payload fields.
	localparam int DATA_W = 32;
	localparam int ID_W   = 4;
	localparam int CFG_W  = 5;

	// What the picker decided for one operation.
	typedef struct packed {
		logic       wr;      // push lands on the target stack
		logic       rd;      // pop removes the top of the target stack
		logic [1:0] status;  // status code reported with the result
	} pick_t;

endpackage

FILE: rtl/lfms_ram.sv
// ----------------------------------------------------------------------------
// lfms_ram
// Generic single-write, single-read RAM with a registered read port. The
// read data holds its value until the next read enable.
// ----------------------------------------------------------------------------
module lfms_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/lfms_pick.sv
// ----------------------------------------------------------------------------
// lfms_pick
// Target selection for one operation: the leftmost stack with room for a
// push, the rightmost non-empty stack for a plain pop, or the named stack
// for a pop-at-stack. Also forms the entry slot that the operation uses.
// ----------------------------------------------------------------------------
module lfms_pick
	import lfms_pkg::*;
#(
	parameter int NUM_STACKS   = 16,
	parameter int MAX_CAPACITY = 16
) (
	input  logic [1:0]                                              opcode,
	input  logic [ID_W-1:0]                                         stack_id,
	input  logic [$clog2(MAX_CAPACITY+1)-1:0]                       eff_cap,
	input  logic [$clog2(MAX_CAPACITY+1)-1:0]                       counts [NUM_STACKS],
	output logic [(NUM_STACKS > 1 ? $clog2(NUM_STACKS) : 1)-1:0]    target,
	output logic [(MAX_CAPACITY > 1 ? $clog2(MAX_CAPACITY) : 1)-1:0] slot,
	output pick_t                                                   pick
);

	localparam int SW  = NUM_STACKS > 1 ? $clog2(NUM_STACKS) : 1;
	localparam int SLW = MAX_CAPACITY > 1 ? $clog2(MAX_CAPACITY) : 1;
	localparam int CW  = $clog2(MAX_CAPACITY+1);

	logic          push_hit;
	logic [SW-1:0] push_idx;
	logic          right_hit;
	logic [SW-1:0] right_idx;
	logic          at_valid;
	logic [SW-1:0] at_idx;
	logic          at_hit;
	logic [CW-1:0] cnt;

	// Leftmost stack below capacity: the lowest index assigned last wins.
	always_comb begin
		push_hit = 1'b0;
		push_idx = '0;
		for (int s = NUM_STACKS - 1; s >= 0; s--) begin
			if (counts[s] < eff_cap) begin
				push_hit = 1'b1;
				push_idx = SW'(s);
			end
		end
	end

	// Rightmost non-empty stack: the highest index assigned last wins.
	always_comb begin
		right_hit = 1'b0;
		right_idx = '0;
		for (int s = 0; s < NUM_STACKS; s++) begin
			if (counts[s] != '0) begin
				right_hit = 1'b1;
				right_idx = SW'(s);
			end
		end
	end

	// Named stack: an id beyond the row behaves as an empty stack.
	assign at_valid = (32'(stack_id) < NUM_STACKS);
	assign at_idx   = SW'(stack_id);
	assign at_hit   = at_valid && (counts[at_idx] != '0);

	// Combine by operation.
	always_comb begin
		target      = '0;
		pick.wr     = 1'b0;
		pick.rd     = 1'b0;
		pick.status = ST_OK;
		case (opcode)
			OP_PUSH: begin
				target      = push_idx;
				pick.wr     = push_hit;
				pick.status = push_hit ? ST_OK : ST_FULL;
			end
			OP_POP_RIGHT: begin
				target      = right_idx;
				pick.rd     = right_hit;
				pick.status = right_hit ? ST_OK : ST_EMPTY;
			end
			OP_POP_AT: begin
				target      = at_idx;
				pick.rd     = at_hit;
				pick.status = at_hit ? ST_OK : ST_EMPTY;
			end
			default: begin
				target = '0;
			end
		endcase
	end

	// A push writes at the fill count, a pop reads just below it.
	assign cnt  = counts[target];
	assign slot = pick.wr ? SLW'(cnt) : SLW'(cnt - CW'(1));

endmodule

FILE: rtl/leftmost_fill_multi_stack_core.sv
// ----------------------------------------------------------------------------
// leftmost_fill_multi_stack_core
// A row of NUM_STACKS stacks of up to MAX_CAPACITY 32-bit entries each.
// Push goes to the leftmost stack with room, pop takes from the rightmost
// non-empty stack, pop-at-stack takes from a named stack.
//
// Usage: operations enter on the in channel (opcode, push_value, stack_id)
// under valid/ready; each produces exactly one result on the out channel
// (pop_value, status, touched_stack), in order. An operation sits in the
// input register, where the target stack is picked from the fill counts,
// the counts are updated and the entry RAM is written or read; the result
// register follows, and the result is offered from it. One operation is
// taken every cycle while out_ready stays high. When the receiver stalls,
// the result holds, the input register holds behind it and in_ready falls.
// Reset clears all fill counts and sets the capacity register to 16; entry
// contents are not cleared and no clearing pass is needed. The user must
// write the capacity register through cfg_we/cfg_data only while the block
// is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module leftmost_fill_multi_stack_core
	import lfms_pkg::*;
#(
	parameter int NUM_STACKS   = 16,
	parameter int MAX_CAPACITY = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// Configuration.
	input  logic                     cfg_we,
	input  logic [CFG_W-1:0]         cfg_data,
	// Operation channel.
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [1:0]               opcode,
	input  logic signed [DATA_W-1:0] push_value,
	input  logic [ID_W-1:0]          stack_id,
	// Result channel.
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [DATA_W-1:0] pop_value,
	output logic [1:0]               status,
	output logic [ID_W-1:0]          touched_stack
);

	localparam int SW    = NUM_STACKS > 1 ? $clog2(NUM_STACKS) : 1;
	localparam int SLW   = MAX_CAPACITY > 1 ? $clog2(MAX_CAPACITY) : 1;
	localparam int CW    = $clog2(MAX_CAPACITY+1);
	localparam int DEPTH = NUM_STACKS * (2 ** SLW);
	localparam int AW    = SW + SLW;

	logic [CFG_W-1:0]  cap_q;
	logic [CW-1:0]     eff_cap;
	logic [CW-1:0]     counts_q [NUM_STACKS];

	logic              valid_s1;
	logic [1:0]        opcode_s1;
	logic [DATA_W-1:0] value_s1;
	logic [ID_W-1:0]   id_s1;

	logic              valid_s2;
	logic              rd_s2;
	logic [1:0]        status_s2;
	logic [ID_W-1:0]   touched_s2;

	logic              adv_s1;
	logic [SW-1:0]     target;
	logic [SLW-1:0]    slot;
	pick_t             pick;
	logic [AW-1:0]     addr;
	logic [DATA_W-1:0] rdata;

	// Capacity register; values above MAX_CAPACITY saturate.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CFG_W'(16);
		end else if (cfg_we) begin
			cap_q <= cfg_data;
		end
	end

	assign eff_cap = (32'(cap_q) > MAX_CAPACITY) ? CW'(MAX_CAPACITY) : CW'(cap_q);

	// Flow control: stage one moves on when the result register is empty or its result is being taken.
	assign adv_s1   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv_s1;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			opcode_s1 <= opcode;
			value_s1  <= push_value;
			id_s1     <= stack_id;
		end
	end

	// Target selection.
	lfms_pick #(
		.NUM_STACKS  (NUM_STACKS),
		.MAX_CAPACITY(MAX_CAPACITY)
	) u_pick (
		.opcode  (opcode_s1),
		.stack_id(id_s1),
		.eff_cap (eff_cap),
		.counts  (counts_q),
		.target  (target),
		.slot    (slot),
		.pick    (pick)
	);

	// Fill counts move with the operation as it leaves stage one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < NUM_STACKS; s++) begin
				counts_q[s] <= '0;
			end
		end else if (adv_s1) begin
			if (pick.wr) begin
				counts_q[target] <= counts_q[target] + CW'(1);
			end else if (pick.rd) begin
				counts_q[target] <= counts_q[target] - CW'(1);
			end
		end
	end

	// Entry storage: stack index in the upper address bits, slot below.
	assign addr = {target, slot};

	lfms_ram #(
		.WIDTH(DATA_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (adv_s1 && pick.wr),
		.waddr(addr),
		.wdata(value_s1),
		.re   (adv_s1 && pick.rd),
		.raddr(addr),
		.rdata(rdata)
	);

	// Result register; the RAM read data holds while the result is stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			rd_s2      <= pick.rd;
			status_s2  <= pick.status;
			touched_s2 <= (pick.wr || pick.rd) ? ID_W'(target) : '0;
		end
	end

	assign out_valid     = valid_s2;
	assign pop_value     = rd_s2 ? rdata : '0;
	assign status        = status_s2;
	assign touched_stack = touched_s2;

endmodule
